>>> src/dtg_pkg.sv
`timescale 1ns / 1ps

package dtg_pkg;

	// Table and fade geometry
	localparam int TABLE_BITS = 10;
	localparam int ROM_SIZE   = 1 << TABLE_BITS;
	localparam int QUARTER    = ROM_SIZE / 4;
	localparam int MAX_FADE   = 512;
	localparam int FADE_W     = $clog2(MAX_FADE + 1);

	// Datapath widths
	localparam int PHASE_W    = 32;
	localparam int SINE_W     = 16;
	localparam int FRAC_W     = 8;
	localparam int GAIN_SHIFT = 30;
	localparam int QUO_W      = GAIN_SHIFT;
	localparam int QCNT_W     = $clog2(QUO_W + 1);
	localparam int MUL_W      = 18;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int Q15_SHIFT  = 15;
	localparam int UNITY_GAIN = 32768;
	localparam int AMP_W      = 15;
	localparam int AMP_FULL   = 32767;
	localparam int LEVEL_MAX  = 100;
	localparam int LEVEL_W    = 7;
	localparam int SLOT_W     = 32;

	localparam longint unsigned PI_HALF_Q40 = 64'd1727108826180;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FADE   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_ROUTE  = CFG_IDX_W'(4);

	localparam logic [1:0] FMT_16 = 2'd0;
	localparam logic [1:0] FMT_24 = 2'd1;

	localparam logic [1:0] ROUTE_LEFT  = 2'd1;
	localparam logic [1:0] ROUTE_RIGHT = 2'd2;

	typedef logic signed [SINE_W-1:0] sine_t;
	typedef sine_t sine_rom_t [ROM_SIZE];
	typedef logic [AMP_W-1:0] amp_lut_t [1 << LEVEL_W];

	typedef struct packed {
		logic              start;
		logic [FADE_W-1:0] num;
		logic [FADE_W-1:0] span;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

	// Divide the k-th Taylor term by (2k)(2k+1)
	function automatic longint unsigned taylor_div(longint unsigned t, int unsigned k);
		case (k)
			1:       return t / 64'd6;
			2:       return t / 64'd20;
			3:       return t / 64'd42;
			4:       return t / 64'd72;
			5:       return t / 64'd110;
			6:       return t / 64'd156;
			7:       return t / 64'd210;
			8:       return t / 64'd272;
			9:       return t / 64'd342;
			10:      return t / 64'd420;
			11:      return t / 64'd506;
			12:      return t / 64'd600;
			default: return t;
		endcase
	endfunction

	// round(32767*sin(pi/2 * r/QUARTER)) by a Q31 Taylor series
	function automatic sine_t quarter_sine(int unsigned r);
		longint unsigned x;
		longint unsigned term;
		longint          sum;
		int unsigned     k;
		x = ((longint'(r) * PI_HALF_Q40) / QUARTER + 64'd256) >> 9;
		term = x;
		sum = longint'(x);
		for (k = 1; k <= 12; k++) begin
			term = (term * x) >> 31;
			term = (term * x) >> 31;
			term = taylor_div(term, k);
			if (k[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		return SINE_W'((longint'(sum) * 64'd32767 + (64'd1 << 30)) >> 31);
	endfunction

	function automatic sine_rom_t build_sine();
		sine_rom_t   rom;
		int unsigned q;
		int unsigned r;
		sine_t       v;
		for (int unsigned i = 0; i < ROM_SIZE; i++) begin
			q = i / QUARTER;
			r = i % QUARTER;
			v = quarter_sine(q[0] ? QUARTER - r : r);
			rom[i] = (q >= 2) ? -v : v;
		end
		return rom;
	endfunction

	// Q15 amplitude for each level code, saturated at full level
	function automatic amp_lut_t build_amp();
		amp_lut_t    lut;
		int unsigned lvl;
		for (int unsigned i = 0; i < (1 << LEVEL_W); i++) begin
			lvl = (i > LEVEL_MAX) ? LEVEL_MAX : i;
			lut[i] = AMP_W'(lvl * AMP_FULL / LEVEL_MAX);
		end
		return lut;
	endfunction

	localparam amp_lut_t AMP_LUT = build_amp();

endpackage

>>> src/dtg_tick_if.sv
`timescale 1ns / 1ps

interface dtg_tick_if;
	logic                         valid;
	logic                         ready;
	logic [dtg_pkg::PHASE_W-1:0]  phase_inc;
	logic                         stop;

	modport source (output valid, phase_inc, stop, input ready);
	modport sink (input valid, phase_inc, stop, output ready);
endinterface

>>> src/dtg_frame_if.sv
`timescale 1ns / 1ps

interface dtg_frame_if;
	logic                               valid;
	logic                               ready;
	logic signed [dtg_pkg::SLOT_W-1:0]  left_slot;
	logic signed [dtg_pkg::SLOT_W-1:0]  right_slot;
	logic                               last;

	modport source (output valid, left_slot, right_slot, last, input ready);
	modport sink (input valid, left_slot, right_slot, last, output ready);
endinterface

>>> src/dtg_sine_rom.sv
`timescale 1ns / 1ps

module dtg_sine_rom (
	input  logic                            clk,
	input  logic [dtg_pkg::TABLE_BITS-1:0]  addr,
	output dtg_pkg::sine_t                  data
);
	import dtg_pkg::*;

	localparam sine_rom_t ROM = build_sine();

	sine_t data_q;

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

	assign data = data_q;

endmodule

>>> src/dtg_divider.sv
`timescale 1ns / 1ps

// Restoring divider: (num << GAIN_SHIFT) / span, one quotient bit a cycle.
// Expects num < span.
module dtg_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  dtg_pkg::div_req_t  req,
	output dtg_pkg::div_rsp_t  rsp
);
	import dtg_pkg::*;

	logic [FADE_W-1:0] rem_q;
	logic [FADE_W-1:0] span_q;
	logic [QUO_W-1:0]  quo_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [FADE_W:0]   rem2;
	logic              take;
	logic [FADE_W:0]   rem_sub;

	assign rem2    = {rem_q, 1'b0};
	assign take    = rem2 >= {1'b0, span_q};
	assign rem_sub = rem2 - {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			span_q <= req.span;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q <= take ? rem_sub[FADE_W-1:0] : rem2[FADE_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], take};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

>>> src/dtg_mult.sv
`timescale 1ns / 1ps

module dtg_mult (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [dtg_pkg::MUL_W-1:0]    a,
	input  logic signed [dtg_pkg::MUL_W-1:0]    b,
	output logic signed [dtg_pkg::PROD_W-1:0]   prod
);
	import dtg_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en)
			prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

>>> src/dds_tone_generator_with_fades_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                            Transaction
// tick      in   phase_inc[31:0], stop              one frame tick
// frame     out  left_slot, right_slot, last        one formatted frame
// cfg       in   cfg_we, cfg_index[2:0], cfg_wdata  one register write
//
// When a fade gain is due, a tick first waits for the serial divider that
// forms the fade phase, then the shared multiplier and the single-port sine
// ROM are stepped through two interpolated look-ups. At unity gain the
// divider and the gain look-up are skipped. A tick after the run has
// ended is taken and gives no frame.
// Reset clears all run state; the registers return to their defaults.
// The finished frame waits in an output register; a stalled sink holds
// only the last step of the following tick.
module dds_tone_generator_with_fades_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	dtg_tick_if.sink                          tick,
	dtg_frame_if.source                       frame,
	input  logic                              cfg_we,
	input  logic [dtg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dtg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import dtg_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_RA,
		ST_RB,
		ST_RW,
		ST_RI,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_FIN
	} state_t;

	// Configuration registers
	logic [LEVEL_W-1:0] level_percent_q;
	logic [9:0]         fade_length_q;
	logic [31:0]        total_frames_q;
	logic [1:0]         sample_format_q;
	logic [1:0]         channel_route_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_percent_q <= LEVEL_W'(LEVEL_MAX);
			fade_length_q   <= 10'd240;
			total_frames_q  <= '0;
			sample_format_q <= FMT_16;
			channel_route_q <= 2'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEVEL:  level_percent_q <= cfg_wdata[LEVEL_W-1:0];
				CFG_FADE:   fade_length_q   <= cfg_wdata[9:0];
				CFG_TOTAL:  total_frames_q  <= cfg_wdata[31:0];
				CFG_FORMAT: sample_format_q <= cfg_wdata[1:0];
				CFG_ROUTE:  channel_route_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Run state and sequencer registers
	state_t                    state_q;
	logic [PHASE_W-1:0]        phase_acc_q;
	logic [31:0]               frame_index_q;
	logic                      stopping_q;
	logic                      ended_q;
	logic [FADE_W-1:0]         fo_idx_q;
	logic [PHASE_W-1:0]        phase_smp_q;
	logic [PHASE_W-1:0]        rd_phase_q;
	logic                      gain_pass_q;
	logic                      last_q;
	sine_t                     a_q;
	logic signed [SINE_W:0]    s_q;
	logic signed [SINE_W:0]    smp_q;
	logic signed [MUL_W-1:0]   g_q;
	logic                      out_valid_q;
	logic signed [SLOT_W-1:0]  left_q;
	logic signed [SLOT_W-1:0]  right_q;
	logic                      out_last_q;

	// Effective fade length: clamp to MAX_FADE, then to half a finite run
	logic              finite;
	logic [FADE_W-1:0] fl_clamp;
	logic [FADE_W-1:0] fl;
	logic [31:0]       fl32;

	assign finite   = total_frames_q != '0;
	assign fl_clamp = (32'(fade_length_q) > 32'(MAX_FADE)) ? FADE_W'(MAX_FADE)
	                                                       : FADE_W'(fade_length_q);
	assign fl = (finite && {fl_clamp, 1'b0} > 33'(total_frames_q))
	            ? FADE_W'(total_frames_q >> 1) : fl_clamp;
	assign fl32 = 32'(fl);

	// Decide what this tick does: emit or not, fade gain, last flag
	logic              stop_new;
	logic              st_next;
	logic [FADE_W-1:0] fo_cur;
	logic [FADE_W-1:0] fo_next;
	logic              emit;
	logic              end_run;
	logic              is_last;
	logic              unity;
	logic [FADE_W-1:0] gnum;
	logic [31:0]       tail;

	assign tail = total_frames_q - frame_index_q;

	always_comb begin
		stop_new = !stopping_q && tick.stop;
		st_next  = stopping_q;
		fo_cur   = stop_new ? '0 : fo_idx_q;
		fo_next  = fo_idx_q;
		emit     = 1'b0;
		end_run  = 1'b0;
		is_last  = 1'b0;
		unity    = 1'b1;
		gnum     = '0;
		if (stop_new) begin
			if (fl == '0)
				end_run = 1'b1;
			else
				st_next = 1'b1;
		end
		if (!end_run) begin
			if (st_next) begin
				if (fo_cur >= fl) begin
					end_run = 1'b1;
				end else begin
					emit    = 1'b1;
					gnum    = fl - fo_cur;
					unity   = fo_cur == '0;
					is_last = fo_cur == fl - 1'b1;
					fo_next = fo_cur + 1'b1;
					end_run = is_last;
				end
			end else if (finite && frame_index_q >= total_frames_q) begin
				end_run = 1'b1;
			end else begin
				emit = 1'b1;
				if (frame_index_q < fl32) begin
					gnum  = FADE_W'(frame_index_q);
					unity = 1'b0;
				end else if (finite && frame_index_q >= total_frames_q - fl32) begin
					gnum  = FADE_W'(tail);
					unity = tail >= fl32;
				end
				is_last = finite && frame_index_q == total_frames_q - 1'b1;
				end_run = is_last;
			end
		end
	end

	logic take_tick;

	assign tick.ready = state_q == ST_IDLE;
	assign take_tick  = tick.valid && tick.ready;

	// Serial divider for the fade phase
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign div_req.start = take_tick && !ended_q && emit && !unity;
	assign div_req.num   = gnum;
	assign div_req.span  = fl;

	dtg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sine ROM, one read a cycle
	logic [TABLE_BITS-1:0] rom_idx;
	logic [TABLE_BITS-1:0] rom_addr;
	logic [FRAC_W-1:0]     frac;
	sine_t                 rom_data;

	assign rom_idx  = rd_phase_q[PHASE_W-1 -: TABLE_BITS];
	assign frac     = rd_phase_q[PHASE_W-TABLE_BITS-1 -: FRAC_W];
	assign rom_addr = (state_q == ST_RB) ? rom_idx + 1'b1 : rom_idx;

	dtg_sine_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	// Shared multiplier: interpolation, gain square, level and fade scaling
	logic [AMP_W-1:0]         amp;
	logic signed [SINE_W:0]   diff;
	logic                     mul_en;
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] mul_prod;

	assign amp  = AMP_LUT[level_percent_q];
	assign diff = {rom_data[SINE_W-1], rom_data} - {a_q[SINE_W-1], a_q};

	always_comb begin
		mul_en = 1'b1;
		mul_a  = MUL_W'(diff);
		mul_b  = MUL_W'(frac);
		case (state_q)
			ST_RW: begin
				mul_a = MUL_W'(diff);
				mul_b = MUL_W'(frac);
			end
			ST_M1: begin
				mul_a = MUL_W'(s_q);
				mul_b = gain_pass_q ? MUL_W'(s_q) : MUL_W'(amp);
			end
			ST_M3: begin
				mul_a = MUL_W'(smp_q);
				mul_b = g_q;
			end
			default: mul_en = 1'b0;
		endcase
	end

	dtg_mult u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_prod)
	);

	// Interpolated sine, scaled values and formatted word
	logic signed [PROD_W-1:0]  interp;
	logic signed [SINE_W:0]    fin_val;
	logic signed [SLOT_W-1:0]  word;
	logic signed [SLOT_W-1:0]  word_fmt;

	assign interp  = PROD_W'(a_q) + (mul_prod >>> FRAC_W);
	assign fin_val = (SINE_W + 1)'(mul_prod >>> Q15_SHIFT);
	assign word    = SLOT_W'(fin_val);

	always_comb begin
		case (sample_format_q)
			FMT_16:  word_fmt = word;
			FMT_24:  word_fmt = word <<< 8;
			default: word_fmt = word <<< 16;
		endcase
	end

	// Load the output register once the finished frame has room
	logic out_load;

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || frame.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_acc_q   <= '0;
			frame_index_q <= '0;
			stopping_q    <= 1'b0;
			ended_q       <= 1'b0;
			fo_idx_q      <= '0;
			phase_smp_q   <= '0;
			rd_phase_q    <= '0;
			gain_pass_q   <= 1'b0;
			last_q        <= 1'b0;
			a_q           <= '0;
			s_q           <= '0;
			smp_q         <= '0;
			g_q           <= '0;
			out_valid_q   <= 1'b0;
			left_q        <= '0;
			right_q       <= '0;
			out_last_q    <= 1'b0;
		end else begin
			// Drop the held frame once the sink takes it, unless a new one lands
			if (out_load)
				out_valid_q <= 1'b1;
			else if (frame.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take_tick && !ended_q) begin
						stopping_q <= st_next;
						fo_idx_q   <= fo_next;
						ended_q    <= end_run;
						if (emit) begin
							last_q      <= is_last;
							phase_smp_q <= phase_acc_q;
							phase_acc_q <= phase_acc_q + tick.phase_inc;
							if (frame_index_q != '1)
								frame_index_q <= frame_index_q + 1'b1;
							if (unity) begin
								g_q         <= MUL_W'(UNITY_GAIN);
								rd_phase_q  <= phase_acc_q;
								gain_pass_q <= 1'b0;
								state_q     <= ST_RA;
							end else begin
								gain_pass_q <= 1'b1;
								state_q     <= ST_DIV;
							end
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						rd_phase_q <= PHASE_W'(div_rsp.quotient);
						state_q    <= ST_RA;
					end
				end
				ST_RA: state_q <= ST_RB;
				ST_RB: begin
					a_q     <= rom_data;
					state_q <= ST_RW;
				end
				ST_RW: state_q <= ST_RI;
				ST_RI: begin
					s_q     <= (SINE_W + 1)'(interp);
					state_q <= ST_M1;
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					if (gain_pass_q) begin
						// Fade gain done: go back for the sample look-up
						g_q         <= MUL_W'(mul_prod >>> Q15_SHIFT);
						rd_phase_q  <= phase_smp_q;
						gain_pass_q <= 1'b0;
						state_q     <= ST_RA;
					end else begin
						smp_q   <= (SINE_W + 1)'(mul_prod >>> Q15_SHIFT);
						state_q <= ST_M3;
					end
				end
				ST_M3: state_q <= ST_FIN;
				ST_FIN: begin
					// Hold the result until the output register is free
					if (out_load) begin
						left_q      <= (channel_route_q == ROUTE_RIGHT) ? '0 : word_fmt;
						right_q     <= (channel_route_q == ROUTE_LEFT) ? '0 : word_fmt;
						out_last_q  <= last_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign frame.valid      = out_valid_q;
	assign frame.left_slot  = left_q;
	assign frame.right_slot = right_q;
	assign frame.last       = out_last_q;

	// Once a run has ended it stays ended
	a_ended_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		ended_q |=> ended_q)
		else $error("run restarted after its end");

	// A frame flagged last leaves the run ended
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && frame.last |-> ended_q)
		else $error("last frame while the run continues");

	// Left-only routing keeps the right slot silent
	a_route_mute: assert property (@(posedge clk) disable iff (!arst_n)
		frame.valid && channel_route_q == ROUTE_LEFT |-> frame.right_slot == '0)
		else $error("right slot not muted");

	// The divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider result outside its wait state");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import dtg_pkg::*;

	typedef longint unsigned u64_t;

	// Codes the package leaves unnamed
	localparam logic [1:0] FMT_32         = 2'd2;
	localparam logic [1:0] FMT_32_ALIAS   = 2'd3;
	localparam logic [1:0] ROUTE_BOTH     = 2'd0;
	localparam logic [1:0] ROUTE_BOTH_ALT = 2'd3;

	localparam u64_t HALF_PI_Q40   = 64'd1727108826180;
	localparam int   RANDOM_ITEMS  = 1880;
	localparam int   CALM_FROM     = 1780;
	localparam int   DRAIN_CYCLES  = 100;
	localparam int   CHOKE_CYCLES  = 400;
	localparam int   CYCLE_LIMIT   = 1000000;

	typedef struct packed {
		logic [SLOT_W-1:0] lslot;
		logic [SLOT_W-1:0] rslot;
		logic              fin;
	} tone_frame_t;

	localparam tone_frame_t SILENT = '0;

	// One row of the directed table: an optional register write made while the
	// block is idle, then one tick; pinned rows carry a hand-written frame.
	typedef struct packed {
		logic                  wr;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic [PHASE_W-1:0]    step;
		logic                  stp;
		logic                  pinned;
		tone_frame_t           want;
	} plan_row_t;

	typedef enum int {
		WIND_NATURAL,
		WIND_STOP_FADE,
		WIND_STOP_NOW,
		WIND_CUT_SHORT,
		WIND_OVERRUN
	} wind_down_t;

	localparam int PLAN_LEN = 20;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		// first tick after reset sits at the bottom of the fade-in: silence
		'{1'b0, CFG_LEVEL,  32'd0,           32'h0000_0000, 1'b0, 1'b1, SILENT},
		// zero level mutes whatever the phase
		'{1'b1, CFG_LEVEL,  32'd0,           32'hFFFF_FFFF, 1'b0, 1'b1, SILENT},
		'{1'b1, CFG_LEVEL,  32'd127,         32'h4000_0000, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FORMAT, 32'(FMT_24),     32'h8000_0000, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FORMAT, 32'(FMT_32),     32'h1234_5678, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FORMAT, 32'(FMT_32_ALIAS), 32'h0000_0001, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_ROUTE,  32'(ROUTE_LEFT), 32'h0ABC_DEF0, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_ROUTE,  32'(ROUTE_RIGHT), 32'h7FFF_FFFF, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_ROUTE,  32'(ROUTE_BOTH_ALT), 32'hF000_0000, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FADE,   32'd0,           32'h1000_0000, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FADE,   32'd1023,        32'h2345_6789, 1'b0, 1'b0, SILENT},
		// short finite run: the ramp is clamped to half the run, tail ramp applies
		'{1'b1, CFG_TOTAL,  32'd20,          32'h0800_0000, 1'b0, 1'b0, SILENT},
		'{1'b0, CFG_TOTAL,  32'd0,           32'h0010_0000, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_TOTAL,  32'hFFFF_FFFF,   32'h0123_4567, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_TOTAL,  32'd0,           32'hDEAD_BEEF, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FADE,   32'd16,          32'h0200_0000, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FADE,   32'd512,         32'h0000_FFFF, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_FORMAT, 32'(FMT_16),     32'hFFFF_FFFF, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_ROUTE,  32'(ROUTE_BOTH), 32'h0000_0000, 1'b0, 1'b0, SILENT},
		'{1'b1, CFG_LEVEL,  32'd100,         32'h8000_0000, 1'b0, 1'b0, SILENT}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	dtg_tick_if  tk ();
	dtg_frame_if fr ();

	dds_tone_generator_with_fades_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tk),
		.frame     (fr),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Predictor state: a private copy of the tone generator and its registers
	int               wave [ROM_SIZE];
	logic [31:0]      tone_phase = '0;
	int unsigned      frame_no = 0;
	int unsigned      fade_pos = 0;
	bit               fading = 1'b0;
	bit               run_over = 1'b0;
	logic [LEVEL_W-1:0] level_reg = 7'd100;
	logic [FADE_W-1:0]  fade_reg = 10'd240;
	logic [31:0]      total_reg = '0;
	logic [1:0]       fmt_reg = FMT_16;
	logic [1:0]       route_reg = ROUTE_BOTH;

	tone_frame_t frames_due [$];
	int          faults = 0;
	bit          calm = 1'b0;
	bit          choke_req = 1'b0;
	bit          choke_seen = 1'b0;
	int          stall_left = 0;
	int          cycle_count = 0;
	logic        offer_pin = 1'b0;
	tone_frame_t offer_want = '0;

	// Quarter-wave sine sample by a Q31 Taylor series, rounded to Q15
	function automatic int quarter_wave(input int unsigned r);
		u64_t   x;
		u64_t   t;
		longint acc;
		x = ((u64_t'(r) * HALF_PI_Q40) / u64_t'(QUARTER) + 64'd256) >> 9;
		t = x;
		acc = longint'(x);
		for (int unsigned k = 1; k <= 12; k++) begin
			t = (t * x) >> 31;
			t = (t * x) >> 31;
			t = t / (u64_t'(2 * k) * u64_t'(2 * k + 1));
			if (k[0])
				acc = acc - longint'(t);
			else
				acc = acc + longint'(t);
		end
		if (acc < 0)
			acc = 0;
		return int'((u64_t'(acc) * 64'd32767 + (64'd1 << 30)) >> 31);
	endfunction

	// Table look-up with linear interpolation on the 8 bits below the index
	function automatic longint interp_sine(input logic [PHASE_W-1:0] ph);
		logic [TABLE_BITS-1:0] i0;
		logic [TABLE_BITS-1:0] i1;
		longint                a;
		longint                b;
		longint                frac;
		i0 = ph[PHASE_W-1 -: TABLE_BITS];
		i1 = i0 + 1'b1;
		frac = longint'(ph[PHASE_W-TABLE_BITS-1 -: FRAC_W]);
		a = longint'(wave[i0]);
		b = longint'(wave[i1]);
		return a + (((b - a) * frac) >>> FRAC_W);
	endfunction

	// Raised-cosine ramp gain in Q15
	function automatic longint ramp_gain(input int unsigned pos, input int unsigned span);
		longint s;
		if (span == 0 || pos >= span)
			return longint'(UNITY_GAIN);
		s = interp_sine(32'((u64_t'(pos) << GAIN_SHIFT) / span));
		return (s * s) >>> Q15_SHIFT;
	endfunction

	function automatic logic [31:0] slot_word(input longint v);
		logic [31:0] u;
		u = 32'(v);
		case (fmt_reg)
			FMT_16:  return {{16{u[15]}}, u[15:0]};
			FMT_24:  return u << 8;
			default: return u << 16;
		endcase
	endfunction

	// Advance the tone generator by one tick; returns 1 when a frame is due
	function automatic bit tone_step(input logic [31:0] step, input logic stp,
			output tone_frame_t res);
		int unsigned span;
		int unsigned lvl;
		int unsigned n;
		longint      amp;
		longint      gain;
		longint      smp;
		logic        fin;
		logic [31:0] word;
		res = '0;
		gain = longint'(UNITY_GAIN);
		fin = 1'b0;
		n = frame_no;
		if (run_over)
			return 1'b0;
		span = (fade_reg > MAX_FADE) ? MAX_FADE : fade_reg;
		lvl = (level_reg > LEVEL_MAX) ? LEVEL_MAX : level_reg;
		amp = longint'(lvl * AMP_FULL / LEVEL_MAX);
		if (total_reg != 0 && 2 * span > total_reg)
			span = total_reg / 2;

		if (!fading && stp) begin
			if (span == 0) begin
				run_over = 1'b1;
				return 1'b0;
			end
			fading = 1'b1;
			fade_pos = 0;
		end

		if (fading) begin
			if (fade_pos >= span) begin
				run_over = 1'b1;
				return 1'b0;
			end
			gain = ramp_gain(span - fade_pos, span);
			fin = (fade_pos == span - 1);
			fade_pos++;
			if (fin)
				run_over = 1'b1;
		end else begin
			if (total_reg != 0 && n >= total_reg) begin
				run_over = 1'b1;
				return 1'b0;
			end
			if (n < span)
				gain = ramp_gain(n, span);
			else if (total_reg != 0 && n >= total_reg - span)
				gain = ramp_gain(total_reg - n, span);
			if (total_reg != 0 && n == total_reg - 1) begin
				fin = 1'b1;
				run_over = 1'b1;
			end
		end

		smp = (interp_sine(tone_phase) * amp) >>> Q15_SHIFT;
		smp = (smp * gain) >>> Q15_SHIFT;
		tone_phase = tone_phase + step;
		if (frame_no != 32'hFFFF_FFFF)
			frame_no++;
		word = slot_word(smp);
		res.lslot = (route_reg == ROUTE_RIGHT) ? '0 : word;
		res.rslot = (route_reg == ROUTE_LEFT) ? '0 : word;
		res.fin = fin;
		return 1'b1;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t ns: %s got %h expected %h", $time, what, got, want);
		faults++;
	endtask

	// Mostly audio-range steps, with the extremes and wide random words mixed in
	function automatic logic [31:0] pick_step();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom;
			default: return $urandom_range(1, 32'h0400_0000);
		endcase
	endfunction

	// Offer one tick transaction, after an optional idle burst, and hold it until taken
	task automatic offer_tick(input logic [31:0] step, input logic stp,
			input logic pin, input tone_frame_t want);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 4);
		@(negedge clk);
		if (gap > 0) begin
			tk.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tk.valid <= 1'b1;
		tk.phase_inc <= step;
		tk.stop <= stp;
		offer_pin = pin;
		offer_want = want;
		do @(posedge clk); while (!(tk.valid && tk.ready));
	endtask

	// Drop valid, wait for every frame owed, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		tk.valid <= 1'b0;
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write one register and mirror it into the predictor at the same edge
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			CFG_LEVEL:  level_reg = val[LEVEL_W-1:0];
			CFG_FADE:   fade_reg = val[FADE_W-1:0];
			CFG_TOTAL:  total_reg = val;
			CFG_FORMAT: fmt_reg = val[1:0];
			CFG_ROUTE:  route_reg = val[1:0];
			default: ;
		endcase
	endtask

	task automatic close_writes();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sink side: random stall bursts, one long hold-off to back the block up,
	// and steady acceptance once the run has gone calm
	always @(negedge clk) begin : frame_sink
		if (!arst_n) begin
			fr.ready <= 1'b0;
		end else if (choke_req && !choke_seen) begin
			choke_seen = 1'b1;
			stall_left = CHOKE_CYCLES - 1;
			fr.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			fr.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 3);
			fr.ready <= 1'b0;
		end else begin
			fr.ready <= 1'b1;
		end
	end

	// Check each frame transaction against the oldest expectation first, then
	// predict from any tick transaction taken at the same edge
	always @(posedge clk) begin : frame_check
		tone_frame_t got;
		tone_frame_t want;
		tone_frame_t calc;
		if (arst_n) begin
			if (fr.valid && fr.ready) begin
				got.lslot = fr.left_slot;
				got.rslot = fr.right_slot;
				got.fin = fr.last;
				if (frames_due.size() == 0) begin
					report("unexpected frame, left_slot", got.lslot, '0);
				end else begin
					want = frames_due.pop_front();
					if (got.lslot !== want.lslot)
						report("left_slot", got.lslot, want.lslot);
					if (got.rslot !== want.rslot)
						report("right_slot", got.rslot, want.rslot);
					if (got.fin !== want.fin)
						report("last", 32'(got.fin), 32'(want.fin));
				end
			end
			if (tk.valid && tk.ready) begin
				if (tone_step(tk.phase_inc, tk.stop, calc))
					frames_due.push_back(offer_pin ? offer_want : calc);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("dds_tone_generator_with_fades_unit verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned q;
		int unsigned r;
		int          v;
		int          rand_sent;
		int          phase_no;
		int          len;
		int          span;
		logic [31:0] total;
		wind_down_t  kind;

		tk.valid = 1'b0;
		tk.phase_inc = '0;
		tk.stop = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LEVEL;
		cfg_wdata = '0;

		// Build the predictor's sine table from the quarter wave by symmetry
		for (int unsigned i = 0; i < ROM_SIZE; i++) begin
			q = i / QUARTER;
			r = i % QUARTER;
			v = quarter_wave(q[0] ? QUARTER - r : r);
			wave[i] = (q >= 2) ? -v : v;
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed table: field extremes, every format and route code, clamps
		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].wr) begin
				settle();
				write_reg(PLAN[i].idx, PLAN[i].data);
				close_writes();
			end
			offer_tick(PLAN[i].step, PLAN[i].stp, PLAN[i].pinned, PLAN[i].want);
		end

		// Random phases. Stop is held low here: a stop ends the run for good, so
		// every phase keeps the frame count short of the run end it programs.
		rand_sent = 0;
		phase_no = 0;
		while (rand_sent < RANDOM_ITEMS) begin
			settle();
			len = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0: total = '0;
				// end of run just out of reach, so the tail ramp is exercised
				1: total = frame_no + len + 1 + $urandom_range(0, 200);
				default: begin
					if ($urandom_range(0, 3) == 0)
						total = 32'hFFFF_FFFF;
					else
						total = frame_no + len + 1 + $urandom_range(1000, 32'h7FFF_0000);
				end
			endcase
			write_reg(CFG_TOTAL, total);
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 4))
					0:       write_reg(CFG_LEVEL, 32'd0);
					1:       write_reg(CFG_LEVEL, 32'd100);
					2:       write_reg(CFG_LEVEL, 32'd127);
					default: write_reg(CFG_LEVEL, $urandom_range(0, 127));
				endcase
			end
			if ($urandom_range(0, 1) == 1) begin
				case ($urandom_range(0, 4))
					0:       write_reg(CFG_FADE, 32'd0);
					1:       write_reg(CFG_FADE, 32'd512);
					2:       write_reg(CFG_FADE, 32'd1023);
					3:       write_reg(CFG_FADE, $urandom_range(1, 8));
					default: write_reg(CFG_FADE, $urandom_range(0, 1023));
				endcase
			end
			if ($urandom_range(0, 1) == 1)
				write_reg(CFG_FORMAT, $urandom_range(0, 3));
			if ($urandom_range(0, 1) == 1)
				write_reg(CFG_ROUTE, $urandom_range(0, 3));
			close_writes();
			// back the block up once while ticks keep coming
			if (phase_no == 3)
				choke_req = 1'b1;
			for (int j = 0; j < len && rand_sent < RANDOM_ITEMS; j++) begin
				offer_tick(pick_step(), 1'b0, 1'b0, SILENT);
				rand_sent++;
				if (rand_sent >= CALM_FROM)
					calm = 1'b1;
			end
			phase_no++;
		end

		// Wind the run down by one of the ways it can end
		settle();
		kind = wind_down_t'($urandom_range(0, 4));
		case (kind)
			WIND_NATURAL: begin
				len = $urandom_range(2, 40);
				write_reg(CFG_TOTAL, 32'(frame_no + len));
				write_reg(CFG_FADE, $urandom_range(0, 1023));
				close_writes();
				repeat (len) offer_tick(pick_step(), 1'b0, 1'b0, SILENT);
			end
			WIND_STOP_FADE: begin
				span = $urandom_range(1, 150);
				write_reg(CFG_TOTAL, 32'd0);
				write_reg(CFG_FADE, span);
				close_writes();
				offer_tick(pick_step(), 1'b1, 1'b0, SILENT);
				// further stops during the fade are ignored
				repeat (span) offer_tick(pick_step(), 1'($urandom_range(0, 1)), 1'b0, SILENT);
			end
			WIND_STOP_NOW: begin
				write_reg(CFG_TOTAL, 32'd0);
				write_reg(CFG_FADE, 32'd0);
				close_writes();
				offer_tick(pick_step(), 1'b1, 1'b0, SILENT);
			end
			WIND_CUT_SHORT: begin
				span = $urandom_range(20, 150);
				write_reg(CFG_TOTAL, 32'd0);
				write_reg(CFG_FADE, span);
				close_writes();
				offer_tick(pick_step(), 1'b1, 1'b0, SILENT);
				len = $urandom_range(1, span - 2);
				repeat (len) offer_tick(pick_step(), 1'($urandom_range(0, 1)), 1'b0, SILENT);
				// shorten the ramp below the frames already faded
				settle();
				write_reg(CFG_FADE, $urandom_range(0, len + 1));
				close_writes();
			end
			default: begin
				// pull the run end below the frame count
				write_reg(CFG_TOTAL, $urandom_range(1, frame_no));
				close_writes();
			end
		endcase
		// ticks after the end are swallowed with no frame
		repeat (12) offer_tick(pick_step(), 1'($urandom_range(0, 1)), 1'b0, SILENT);

		settle();
		if (faults == 0)
			$display("dds_tone_generator_with_fades_unit verification clean");
		else
			$display("dds_tone_generator_with_fades_unit verification failed");
		$finish;
	end

endmodule
